// ===== rtl/rld_pkg.sv =====
// Shared types and constants for the radial lens distortion map.
// Holds the configuration register struct, register indexes, field widths
// and the intermediate clamp limits. No dependencies.
package rld_pkg;

  // Field and register widths
  localparam int IN_W        = 17;
  localparam int OUT_W       = 20;
  localparam int REG_W       = 24;
  localparam int COEF_FRAC   = 20;
  localparam int CFG_IDX_W   = 8;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // Pipeline depth of the datapath
  localparam int RLD_STAGES = 10;

  // Intermediate widths, set by the clamp limits below
  localparam int SR_W = 31;
  localparam int S2_W = 38;
  localparam int FR_W = 36;
  localparam int T_W  = 38;

  localparam logic [63:0]        SR_MAX  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0]        S2_MAX  = 64'h0000_003F_FFFF_FFFF;
  localparam logic signed [63:0] FR_LIM  = 64'sd17179869184;
  localparam logic signed [63:0] T_LIM   = 64'sd68719476736;
  localparam logic signed [63:0] OUT_MAX = 64'sd524287;
  localparam logic signed [63:0] OUT_MIN = -64'sd524288;

  // Reset value of the zoom registers: 1.0 with 20 fraction bits
  localparam logic [REG_W-1:0] ZOOM_ONE = 24'h100000;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIAL_K1 = 8'd0,
    REG_RADIAL_K2 = 8'd1,
    REG_ZOOM_X    = 8'd2,
    REG_ZOOM_Y    = 8'd3
  } rld_reg_t;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic signed [REG_W-1:0] k1;
    logic signed [REG_W-1:0] k2;
    logic [REG_W-1:0]        zoom_x;
    logic [REG_W-1:0]        zoom_y;
  } rld_cfg_t;

endpackage

// ===== rtl/radial_lens_distortion_map.sv =====
// Radial lens distortion map, top level: stream handshake, configuration
// registers and per-stage valid bits around the datapath.
// Depends on rld_pkg and rld_datapath.
//
// Usage: each input word on s_axis carries one normalized (u,v) pair; each
// output word on m_axis carries the distorted (x,y) pair, with the clip flag
// on m_axis_tuser. Exactly one output word per input word, in order.
// The configuration channel writes k1, k2, zoom_x and zoom_y by index; it is
// always ready and should only be written while no word is in flight.
// Pipeline: the accepting edge loads a word into the first of the ten register
// stages, and m_axis presents it from the last. Five multiplier stages
// (squares, sr squared with k1*sr, k2*s2, d*f, zoom) alternate with rounding
// and limiting stages.
// Throughput: one word per cycle while m_axis_tready is not held low.
// Reset: rst (synchronous) empties the pipeline, sets k1 = k2 = 0 and both
// zooms to 1.0. Stall: each stage holds while the one after it is full and
// blocked; empty stages keep filling, so s_axis_tready drops only when all
// ten stages hold words and m_axis_tready is low, or while rst is high.
module radial_lens_distortion_map #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // s_axis_tdata: coord_u[16:0], coord_v[33:17], zero pad [39:34]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rld_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // m_axis_tdata: mapped_x[19:0], mapped_y[39:20]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rld_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // m_axis_tuser: clipped[0]
  output logic [0:0]                          m_axis_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rld_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rld_pkg::REG_W-1:0]           cfg_data
);
  import rld_pkg::*;

  rld_cfg_t                cfg;
  logic [RLD_STAGES-1:0]   vld;
  logic [RLD_STAGES-1:0]   en;
  logic signed [OUT_W-1:0] mapped_x, mapped_y;
  logic                    clipped;
  logic                    in_acc, out_acc;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.k1     <= '0;
      cfg.k2     <= '0;
      cfg.zoom_x <= ZOOM_ONE;
      cfg.zoom_y <= ZOOM_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RADIAL_K1: cfg.k1     <= $signed(cfg_data);
        REG_RADIAL_K2: cfg.k2     <= $signed(cfg_data);
        REG_ZOOM_X:    cfg.zoom_x <= cfg_data;
        REG_ZOOM_Y:    cfg.zoom_y <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its word moves on
  always_comb begin
    en[RLD_STAGES-1] = !vld[RLD_STAGES-1] || m_axis_tready;
    for (int k = RLD_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0] && !rst;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  // Valid bits travel with the stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < RLD_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  rld_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .en       (en),
    .coord_u  (s_axis_tdata[IN_W-1:0]),
    .coord_v  (s_axis_tdata[2*IN_W-1:IN_W]),
    .cfg      (cfg),
    .mapped_x (mapped_x),
    .mapped_y (mapped_y),
    .clipped  (clipped)
  );

  // Output word
  assign m_axis_tvalid = vld[RLD_STAGES-1];
  assign m_axis_tdata  = {mapped_y, mapped_x};
  assign m_axis_tuser  = clipped;

`ifndef NO_ASSERTIONS
  // Input backpressure only when every stage holds a word
  a_no_stall_with_bubble: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (&vld))
    else $error("input stalled while the pipeline has an empty stage");

  // Words in flight change only by accepts and deliveries
  a_word_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(vld) ==
      $past($countones(vld)) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("word lost or duplicated in the pipeline");

  // Pipeline is empty coming out of reset
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> (vld == '0) && !m_axis_tvalid)
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== rtl/rld_datapath.sv =====
// Ten-stage fixed-point datapath of the radial lens distortion map.
// Each stage register loads when its enable bit is high; valid bits live in
// the top level. Depends on rld_pkg.
module rld_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic [rld_pkg::RLD_STAGES-1:0]         en,
  input  logic [rld_pkg::IN_W-1:0]               coord_u,
  input  logic [rld_pkg::IN_W-1:0]               coord_v,
  input  rld_pkg::rld_cfg_t                      cfg,
  output logic signed [rld_pkg::OUT_W-1:0]       mapped_x,
  output logic signed [rld_pkg::OUT_W-1:0]       mapped_y,
  output logic                                   clipped
);
  import rld_pkg::*;

  // Offset coordinate must hold -0.5 and the largest raw input
  localparam int DW = ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 1;
  localparam int PW = 2 * DW;
  localparam int UW = DW + FR_W;
  localparam int ZW = T_W + REG_W + 1;
  localparam int KW1 = REG_W + SR_W + 1;
  localparam int KW2 = REG_W + S2_W + 1;
  localparam logic [63:0]        HALF_F  = 64'd1 << (FRAC_BITS - 1);
  localparam logic signed [63:0] HALF_FS = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] HALF_CS = 64'sd1 <<< (COEF_FRAC - 1);
  localparam logic signed [63:0] ONE_FS  = 64'sd1 <<< (FRAC_BITS + COEF_FRAC);

  // Stage 0: center offset and squares
  logic signed [DW-1:0] du_c, dv_c;
  logic signed [DW-1:0] du0, dv0;
  logic signed [PW-1:0] squ0, sqv0;

  assign du_c = $signed(DW'(coord_u)) - $signed(DW'(HALF_F));
  assign dv_c = $signed(DW'(coord_v)) - $signed(DW'(HALF_F));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      du0  <= du_c;
      dv0  <= dv_c;
      squ0 <= du_c * du_c;
      sqv0 <= dv_c * dv_c;
    end
  end

  // Stage 1: radius squared, rounded to F fraction bits and limited
  logic [63:0]          sum1_c, sr1_full;
  logic [SR_W-1:0]      sr1_c;
  logic                 fl1_c;
  logic [SR_W-1:0]      sr1;
  logic                 fl1;
  logic signed [DW-1:0] du1, dv1;

  always_comb begin
    sum1_c   = 64'($unsigned(squ0)) + 64'($unsigned(sqv0)) + HALF_F;
    sr1_full = sum1_c >> FRAC_BITS;
    fl1_c    = 1'b0;
    sr1_c    = sr1_full[SR_W-1:0];
    if (sr1_full > SR_MAX) begin
      sr1_c = SR_MAX[SR_W-1:0];
      fl1_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sr1 <= sr1_c;
      fl1 <= fl1_c;
      du1 <= du0;
      dv1 <= dv0;
    end
  end

  // Stage 2: sr squared and the second-order term
  logic [2*SR_W-1:0]     srsq2;
  logic signed [KW1-1:0] k1sr2;
  logic                  fl2;
  logic signed [DW-1:0]  du2, dv2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      srsq2 <= sr1 * sr1;
      k1sr2 <= cfg.k1 * $signed({1'b0, sr1});
      fl2   <= fl1;
      du2   <= du1;
      dv2   <= dv1;
    end
  end

  // Stage 3: round sr^2 and limit it
  logic [63:0]           s2_sum_c, s2_full;
  logic [S2_W-1:0]       s2_c;
  logic                  fl3_c;
  logic [S2_W-1:0]       s23;
  logic signed [KW1-1:0] k1sr3;
  logic                  fl3;
  logic signed [DW-1:0]  du3, dv3;

  always_comb begin
    s2_sum_c = 64'(srsq2) + HALF_F;
    s2_full  = s2_sum_c >> FRAC_BITS;
    fl3_c    = fl2;
    s2_c     = s2_full[S2_W-1:0];
    if (s2_full > S2_MAX) begin
      s2_c  = S2_MAX[S2_W-1:0];
      fl3_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s23   <= s2_c;
      k1sr3 <= k1sr2;
      fl3   <= fl3_c;
      du3   <= du2;
      dv3   <= dv2;
    end
  end

  // Stage 4: fourth-order term
  logic signed [KW2-1:0] k2s24;
  logic signed [KW1-1:0] k1sr4;
  logic                  fl4;
  logic signed [DW-1:0]  du4, dv4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      k2s24 <= cfg.k2 * $signed({1'b0, s23});
      k1sr4 <= k1sr3;
      fl4   <= fl3;
      du4   <= du3;
      dv4   <= dv3;
    end
  end

  // Stage 5: distortion factor f, rounded to F fraction bits and limited
  logic signed [63:0]   fsum_c, fr_full;
  logic signed [FR_W-1:0] fr_c;
  logic                 fl5_c;
  logic signed [FR_W-1:0] fr5;
  logic                 fl5;
  logic signed [DW-1:0] du5, dv5;

  always_comb begin
    fsum_c  = ONE_FS + HALF_CS + 64'(k1sr4) + 64'(k2s24);
    fr_full = fsum_c >>> COEF_FRAC;
    fl5_c   = fl4;
    fr_c    = fr_full[FR_W-1:0];
    if (fr_full > FR_LIM) begin
      fr_c  = FR_LIM[FR_W-1:0];
      fl5_c = 1'b1;
    end else if (fr_full < -FR_LIM) begin
      fr_c  = FR_W'(-FR_LIM);
      fl5_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      fr5 <= fr_c;
      fl5 <= fl5_c;
      du5 <= du4;
      dv5 <= dv4;
    end
  end

  // Stage 6: scale the offsets by f
  logic signed [UW-1:0] pu6, pv6;
  logic                 fl6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      pu6 <= du5 * fr5;
      pv6 <= dv5 * fr5;
      fl6 <= fl5;
    end
  end

  // Stage 7: round to F fraction bits and limit
  logic signed [63:0]    tu_full, tv_full;
  logic signed [T_W-1:0] tu_c, tv_c;
  logic                  fl7_c;
  logic signed [T_W-1:0] tu7, tv7;
  logic                  fl7;

  always_comb begin
    tu_full = (64'(pu6) + HALF_FS) >>> FRAC_BITS;
    tv_full = (64'(pv6) + HALF_FS) >>> FRAC_BITS;
    fl7_c   = fl6;
    tu_c    = tu_full[T_W-1:0];
    tv_c    = tv_full[T_W-1:0];
    if (tu_full > T_LIM) begin
      tu_c  = T_LIM[T_W-1:0];
      fl7_c = 1'b1;
    end else if (tu_full < -T_LIM) begin
      tu_c  = T_W'(-T_LIM);
      fl7_c = 1'b1;
    end
    if (tv_full > T_LIM) begin
      tv_c  = T_LIM[T_W-1:0];
      fl7_c = 1'b1;
    end else if (tv_full < -T_LIM) begin
      tv_c  = T_W'(-T_LIM);
      fl7_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      tu7 <= tu_c;
      tv7 <= tv_c;
      fl7 <= fl7_c;
    end
  end

  // Stage 8: zoom
  logic signed [ZW-1:0] zu8, zv8;
  logic                 fl8;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      zu8 <= tu7 * $signed({1'b0, cfg.zoom_x});
      zv8 <= tv7 * $signed({1'b0, cfg.zoom_y});
      fl8 <= fl7;
    end
  end

  // Stage 9: round, move back to the 0.5 center, saturate to the output range
  logic signed [63:0]      ox_full, oy_full;
  logic signed [OUT_W-1:0] ox_c, oy_c;
  logic                    fl9_c;

  always_comb begin
    ox_full = ((64'(zu8) + HALF_CS) >>> COEF_FRAC) + HALF_FS;
    oy_full = ((64'(zv8) + HALF_CS) >>> COEF_FRAC) + HALF_FS;
    fl9_c   = fl8;
    ox_c    = ox_full[OUT_W-1:0];
    oy_c    = oy_full[OUT_W-1:0];
    if (ox_full > OUT_MAX) begin
      ox_c  = OUT_MAX[OUT_W-1:0];
      fl9_c = 1'b1;
    end else if (ox_full < OUT_MIN) begin
      ox_c  = OUT_MIN[OUT_W-1:0];
      fl9_c = 1'b1;
    end
    if (oy_full > OUT_MAX) begin
      oy_c  = OUT_MAX[OUT_W-1:0];
      fl9_c = 1'b1;
    end else if (oy_full < OUT_MIN) begin
      oy_c  = OUT_MIN[OUT_W-1:0];
      fl9_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      mapped_x <= ox_c;
      mapped_y <= oy_c;
      clipped  <= fl9_c;
    end
  end

endmodule
